FILE: rtl/dtwr_pkg.sv
// ----------------------------------------------------------------------------
// dtwr_pkg
// shared constants and types of the two-way ranging distance unit
// ----------------------------------------------------------------------------
`default_nettype none
package dtwr_pkg;

  localparam int STAMP_BITS_DEF     = 32;
  localparam int QUOT_FRAC_BITS_DEF = 8;
  localparam int TS_BITS            = 32;
  localparam int NUM_STAMPS         = 6;
  localparam int CAL_BITS           = 17;
  localparam int SCALE_BITS         = 24;
  localparam int DIST_BITS          = 32;
  localparam int CAP_BIT            = 40;
  localparam int SCALE_FRAC_BITS    = 16;
  localparam int CHUNK_BITS         = 32;

  localparam logic [CAL_BITS-1:0]   CAL_RESET   = '0;
  localparam logic [SCALE_BITS-1:0] SCALE_RESET = 24'd307386;

  localparam logic [0:0] REG_CAL   = 1'b0;
  localparam logic [0:0] REG_SCALE = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_DEN0 = 2'd2;
  localparam logic [1:0] STATUS_SAT  = 2'd3;

  typedef struct packed {
    logic valid;
    logic zero;
    logic neg;
  } dtwr_side_t;

endpackage
`default_nettype wire

FILE: rtl/dtwr_front.sv
// ----------------------------------------------------------------------------
// dtwr_front
// intervals, products and signed numerator magnitude, three stages
// ----------------------------------------------------------------------------
`default_nettype none
module dtwr_front import dtwr_pkg::*; #(
  parameter int S = STAMP_BITS_DEF,
  parameter int F = QUOT_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [NUM_STAMPS*TS_BITS-1:0] stamps,
  output logic [2*S+F-1:0]                   num,
  output logic [S+1:0]                       den,
  output dtwr_side_t                         side
);
  localparam int DW = S + 2;
  localparam int NB = 2 * S + F;

  logic [S-1:0] rps, rrs, rfs, lps, lrs, lfs;
  logic [S-1:0] ra_next, rb_next, da_next, db_next;
  logic [DW-1:0] den_next;
  logic [S-1:0] ra, rb, da, db;
  logic [DW-1:0] den_a, den_b;
  dtwr_side_t side_a, side_b;
  logic [2*S-1:0] pa, pb;

  assign rps = S'(stamps[0*TS_BITS +: TS_BITS]);
  assign rrs = S'(stamps[1*TS_BITS +: TS_BITS]);
  assign rfs = S'(stamps[2*TS_BITS +: TS_BITS]);
  assign lps = S'(stamps[3*TS_BITS +: TS_BITS]);
  assign lrs = S'(stamps[4*TS_BITS +: TS_BITS]);
  assign lfs = S'(stamps[5*TS_BITS +: TS_BITS]);

  assign ra_next  = rrs - rps;
  assign rb_next  = lfs - lrs;
  assign da_next  = rfs - rrs;
  assign db_next  = lrs - lps;
  assign den_next = DW'(ra_next) + DW'(rb_next) + DW'(da_next) + DW'(db_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a <= '0;
      side_b <= '0;
      side   <= '0;
    end else if (en) begin
      side_a <= '{valid: in_valid, zero: (den_next == '0), neg: 1'b0};
      side_b <= side_a;
      side   <= '{valid: side_b.valid, zero: side_b.zero, neg: (pa < pb)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra    <= ra_next;
      rb    <= rb_next;
      da    <= da_next;
      db    <= db_next;
      den_a <= den_next;
      pa    <= (2*S)'(ra) * (2*S)'(rb);
      pb    <= (2*S)'(da) * (2*S)'(db);
      den_b <= den_a;
      num   <= (pa >= pb) ? (NB'(pa - pb) << F) : (NB'(pb - pa) << F);
      den   <= den_b;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dtwr_div_cell.sv
// ----------------------------------------------------------------------------
// dtwr_div_cell
// one restoring divide step, one quotient bit, registered
// ----------------------------------------------------------------------------
`default_nettype none
module dtwr_div_cell import dtwr_pkg::*; #(
  parameter int S = STAMP_BITS_DEF,
  parameter int F = QUOT_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic [3*S+F+1:0]  work_in,
  input  wire logic [S+1:0]      den_in,
  input  wire dtwr_side_t        side_in,
  output logic [3*S+F+1:0]       work_out,
  output logic [S+1:0]           den_out,
  output dtwr_side_t             side_out
);
  localparam int DW = S + 2;
  localparam int NB = 2 * S + F;
  localparam int W  = DW + NB;

  logic [DW:0]   top;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;

  assign top      = work_in[W-1:NB-1];
  assign diff     = top - {1'b0, den_in};
  assign ge       = (top >= {1'b0, den_in});
  assign rem_next = ge ? diff[DW-1:0] : top[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (en) begin
      side_out <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_out <= {rem_next, work_in[NB-2:0], ge};
      den_out  <= den_in;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/dtwr_back.sv
// ----------------------------------------------------------------------------
// dtwr_back
// scaling to millimetres, offset, clamp and output register
// ----------------------------------------------------------------------------
`default_nettype none
module dtwr_back import dtwr_pkg::*; #(
  parameter int S = STAMP_BITS_DEF,
  parameter int F = QUOT_FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic [2*S+F-1:0]       quot,
  input  wire dtwr_side_t             side_in,
  input  wire logic [CAL_BITS-1:0]    cal,
  input  wire logic [SCALE_BITS-1:0]  scale,
  output logic                        out_valid,
  output logic [DIST_BITS-1:0]        distance_mm,
  output logic [1:0]                  status
);
  localparam int QN  = 2 * S + F;
  localparam int QW  = (QN < 57 + F) ? QN : 57 + F;
  localparam int NCH = (QW + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int PB  = CHUNK_BITS + SCALE_BITS;
  localparam int PW  = NCH * CHUNK_BITS + SCALE_BITS;
  localparam int SH  = SCALE_FRAC_BITS + F;
  localparam int SHW = PW - SH;

  localparam logic [CAP_BIT:0] CAP = (CAP_BIT+1)'(1) << CAP_BIT;

  logic [QW-1:0]               qc;
  logic [NCH*CHUNK_BITS-1:0]   qp;
  logic [PB-1:0]               prod [NCH];
  dtwr_side_t                  side_p, side_m;
  logic [PW-1:0]               sum;
  logic [SHW-1:0]              shifted;
  logic [CAP_BIT:0]            mag_next, mag;
  logic [CAP_BIT+1:0]          sval;
  logic [CAP_BIT+2:0]          calv;
  logic [DIST_BITS-1:0]        dist_next;
  logic [1:0]                  status_next;

  generate
    if (QN > QW) begin : g_clip
      assign qc = (|quot[QN-1:QW]) ? '1 : quot[QW-1:0];
    end else begin : g_pass
      assign qc = quot[QW-1:0];
    end
  endgenerate

  assign qp = (NCH*CHUNK_BITS)'(qc);

  always_comb begin
    sum = '0;
    for (int k = 0; k < NCH; k++) begin
      sum = sum + (PW'(prod[k]) << (CHUNK_BITS * k));
    end
  end

  assign shifted  = sum[PW-1:SH];
  assign mag_next = (shifted > SHW'(CAP)) ? CAP : shifted[CAP_BIT:0];

  assign sval = side_m.neg ? ((CAP_BIT+2)'(0) - {1'b0, mag}) : {1'b0, mag};
  assign calv = {sval[CAP_BIT+1], sval}
              + {{(CAP_BIT+3-CAL_BITS){cal[CAL_BITS-1]}}, cal};

  always_comb begin
    if (side_m.zero) begin
      dist_next   = '1;
      status_next = STATUS_DEN0;
    end else if (calv[CAP_BIT+2] || (calv == '0)) begin
      dist_next   = '0;
      status_next = STATUS_ZERO;
    end else if (|calv[CAP_BIT+1:DIST_BITS]) begin
      dist_next   = '1;
      status_next = STATUS_SAT;
    end else begin
      dist_next   = calv[DIST_BITS-1:0];
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_p    <= '0;
      side_m    <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      side_p    <= side_in;
      side_m    <= side_p;
      out_valid <= side_m.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NCH; k++) begin
        prod[k] <= PB'(qp[CHUNK_BITS*k +: CHUNK_BITS]) * PB'(scale);
      end
      mag         <= mag_next;
      distance_mm <= dist_next;
      status      <= status_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ds_twr_distance_from_timestamps_unit.sv
// ----------------------------------------------------------------------------
// ds_twr_distance_from_timestamps_unit
// distance from the six timestamps of one double-sided ranging exchange
// ----------------------------------------------------------------------------
// Takes one exchange per clock cycle unless the result side stalls, and returns
// one distance beat for each, in order. The time-of-flight divider is a chain of
// cells that each produce one quotient bit; three stages before it form the
// intervals and products, three after it scale, calibrate and clamp. A stall
// on the result side holds the whole pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module ds_twr_distance_from_timestamps_unit import dtwr_pkg::*; #(
  parameter int STAMP_BITS     = STAMP_BITS_DEF,
  parameter int QUOT_FRAC_BITS = QUOT_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // remote_poll_sent, remote_reply_seen, remote_final_sent,
  // local_poll_seen, local_reply_sent, local_final_seen
  input  wire logic [NUM_STAMPS*TS_BITS-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // distance_mm
  output logic [DIST_BITS-1:0]                m_tdata,
  // status
  output logic [1:0]                          m_tuser,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  localparam int S  = STAMP_BITS;
  localparam int F  = QUOT_FRAC_BITS;
  localparam int DW = S + 2;
  localparam int NB = 2 * S + F;
  localparam int W  = DW + NB;

  logic                  en;
  logic [CAL_BITS-1:0]   cal;
  logic [SCALE_BITS-1:0] scale;
  logic [NB-1:0]         num;
  logic [DW-1:0]         den;
  dtwr_side_t            side_f;
  logic [W-1:0]          work_c [NB+1];
  logic [DW-1:0]         den_c  [NB+1];
  dtwr_side_t            side_c [NB+1];

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal   <= CAL_RESET;
      scale <= SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_CAL:   cal   <= pwdata[CAL_BITS-1:0];
        REG_SCALE: scale <= pwdata[SCALE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAL:   prdata = {{(32-CAL_BITS){cal[CAL_BITS-1]}}, cal};
      REG_SCALE: prdata = 32'(scale);
      default:   prdata = '0;
    endcase
  end

  dtwr_front #(.S(S), .F(F)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .stamps   (s_tdata),
    .num      (num),
    .den      (den),
    .side     (side_f)
  );

  assign work_c[0] = {DW'(0), num};
  assign den_c[0]  = den;
  assign side_c[0] = side_f;

  generate
    for (genvar i = 0; i < NB; i++) begin : g_cell
      dtwr_div_cell #(.S(S), .F(F)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .work_in  (work_c[i]),
        .den_in   (den_c[i]),
        .side_in  (side_c[i]),
        .work_out (work_c[i+1]),
        .den_out  (den_c[i+1]),
        .side_out (side_c[i+1])
      );
    end
  endgenerate

  dtwr_back #(.S(S), .F(F)) u_back (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .quot        (work_c[NB][NB-1:0]),
    .side_in     (side_c[NB]),
    .cal         (cal),
    .scale       (scale),
    .out_valid   (m_tvalid),
    .distance_mm (m_tdata),
    .status      (m_tuser)
  );

endmodule
`default_nettype wire
